// ===== hdl/tree_path_max_edge_query_macros.svh =====
// Assertion macros for the tree path maximum edge query block.
// Used by the port checker; needs nothing else.
`ifndef TREE_PATH_MAX_EDGE_QUERY_MACROS_SVH
`define TREE_PATH_MAX_EDGE_QUERY_MACROS_SVH

// Consequent checked in the cycle after the antecedent.
`define TPMQ_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("tpmq: port check failed");

// Consequent checked in the same cycle as the antecedent.
`define TPMQ_ASSERT_SAME(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("tpmq: port check failed");

`endif

// ===== hdl/tpmq_pkg.sv =====
// Shared types and constants of the tree path maximum edge query block.
// No dependencies; the other files but tpmq_lift_mem and the macro header take names from here by scope.
`timescale 1ns / 1ps
`default_nettype none

package tpmq_pkg;

	localparam int MAX_NODES_DEF   = 65536;
	localparam int LEVELS_DEF      = 17;
	localparam int WEIGHT_BITS_DEF = 20;

	localparam int NODE_W  = 16;
	localparam int DEPTH_W = 16;
	localparam int CFG_W   = 17;
	localparam int EDGE_W  = 20;

	localparam logic [1:0] KIND_LOAD  = 2'd0;
	localparam logic [1:0] KIND_BUILD = 2'd1;
	localparam logic [1:0] KIND_QUERY = 2'd2;

	typedef enum logic [4:0] {
		OP_NONE,
		OP_CLR,
		OP_CAPTURE,
		OP_LOAD,
		OP_RD_S,
		OP_RD_M,
		OP_WR,
		OP_NEXT_LVL,
		OP_Q_DEP,
		OP_Q_SWAP,
		OP_P1_RD,
		OP_P1_UPD,
		OP_Q_EQ,
		OP_P2_RD,
		OP_P2_UPD,
		OP_F_RD,
		OP_F_UPD,
		OP_OUT
	} op_t;

	typedef struct packed {
		op_t op;
	} cmd_t;

	typedef struct packed {
		logic clr_last;
		logic lvl_ok;
		logic idx_last;
		logic lvl_zero;
		logic xy_equal;
		logic out_free;
	} stat_t;

endpackage

`default_nettype wire

// ===== hdl/tree_path_max_edge_query.sv =====
// Tree path maximum edge query. Load items write one node's depth, parent and
// parent-edge weight; a build item fills the binary-lifting tables level by
// level; a query item returns the largest edge weight on the path between two
// nodes (0 for a node with itself). After reset the block sweeps the lifting
// tables clear, one node per cycle, and holds req_stall high meanwhile;
// node_count writes are taken at any time. A load is captured, then written in
// state S_LOAD. In a query each lifting level costs one registered table read
// plus one update, once while the deeper node climbs and once while both climb
// (skipped when the nodes meet). A build steps through each node of each level
// with two dependent reads (own entry, then the middle ancestor's) and the
// write that each table entry needs. A finished result waits in the output
// register while the next item is accepted. Node numbers wrap modulo
// MAX_NODES, which is taken to be a power of two.
// Depends on tpmq_pkg, tpmq_ctrl, tpmq_datapath, tpmq_lift_mem.
`timescale 1ns / 1ps
`default_nettype none

module tree_path_max_edge_query #(
	parameter int MAX_NODES   = tpmq_pkg::MAX_NODES_DEF,
	parameter int LEVELS      = tpmq_pkg::LEVELS_DEF,
	parameter int WEIGHT_BITS = tpmq_pkg::WEIGHT_BITS_DEF
) (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	// configuration: node_count
	input  wire logic                         cfg_valid,
	output logic                              cfg_ready,
	input  wire logic [tpmq_pkg::CFG_W-1:0]   cfg_data,
	// request channel
	input  wire logic                         req_valid,
	output logic                              req_stall,
	input  wire logic [1:0]                   kind,
	input  wire logic [tpmq_pkg::NODE_W-1:0]  node,
	input  wire logic [tpmq_pkg::NODE_W-1:0]  other_node,
	input  wire logic [tpmq_pkg::NODE_W-1:0]  parent_node,
	input  wire logic                         has_parent,
	input  wire logic [tpmq_pkg::DEPTH_W-1:0] node_depth_in,
	input  wire logic [tpmq_pkg::EDGE_W-1:0]  edge_weight,
	// result channel
	output logic                              rsp_valid,
	input  wire logic                         rsp_stall,
	output logic      [WEIGHT_BITS-1:0]       max_weight
);

	tpmq_pkg::cmd_t  cmd;
	tpmq_pkg::stat_t stat;

	// The register write needs no wait: node_count is a plain flop.
	assign cfg_ready = 1'b1;

	// Sequencer: clear sweep, then one item at a time.
	tpmq_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.kind      (kind),
		.req_stall (req_stall),
		.stat      (stat),
		.cmd       (cmd)
	);

	// Tables, lifting registers and the result register.
	tpmq_datapath #(
		.MAX_NODES (MAX_NODES),
		.LEVELS    (LEVELS),
		.WB        (WEIGHT_BITS)
	) u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.stat          (stat),
		.cfg_valid     (cfg_valid),
		.cfg_data      (cfg_data),
		.node          (node),
		.other_node    (other_node),
		.parent_node   (parent_node),
		.has_parent    (has_parent),
		.node_depth_in (node_depth_in),
		.edge_weight   (edge_weight),
		.rsp_stall     (rsp_stall),
		.rsp_valid     (rsp_valid),
		.max_weight    (max_weight)
	);

endmodule

`default_nettype wire

// ===== hdl/tpmq_lift_mem.sv =====
// Binary-lifting tables: one memory per level, entry = {valid, ancestor, max}.
// Depends on nothing but its parameters.
`timescale 1ns / 1ps
`default_nettype none

module tpmq_lift_mem #(
	parameter int MAX_NODES = 65536,
	parameter int LEVELS    = 17,
	parameter int WB        = 20
) (
	input  wire logic                          clk,
	input  wire logic [LEVELS-1:0]             wr_en,
	input  wire logic [$clog2(MAX_NODES)-1:0]  wr_addr,
	input  wire logic [$clog2(MAX_NODES)+WB:0] wr_data0,
	input  wire logic [$clog2(MAX_NODES)+WB:0] wr_data_hi,
	input  wire logic [$clog2(MAX_NODES)-1:0]  rd_addr_a,
	input  wire logic [$clog2(MAX_NODES)-1:0]  rd_addr_b,
	input  wire logic [$clog2(LEVELS)-1:0]     rd_lvl,
	output logic      [$clog2(MAX_NODES)+WB:0] rd_data_a,
	output logic      [$clog2(MAX_NODES)+WB:0] rd_data_b
);

	localparam int NW = $clog2(MAX_NODES);
	localparam int LW = $clog2(LEVELS);
	localparam int EW = 1 + NW + WB;

	logic [EW-1:0] qa_w [LEVELS];
	logic [EW-1:0] qb_w [LEVELS];
	logic [LW-1:0] rd_lvl_q;

	for (genvar g = 0; g < LEVELS; g++) begin : g_lvl
		logic [EW-1:0] mem [MAX_NODES];
		logic [EW-1:0] qa_q;
		logic [EW-1:0] qb_q;

		always_ff @(posedge clk) begin
			if (wr_en[g]) begin
				mem[wr_addr] <= (g == 0) ? wr_data0 : wr_data_hi;
			end
			qa_q <= mem[rd_addr_a];
			qb_q <= mem[rd_addr_b];
		end

		assign qa_w[g] = qa_q;
		assign qb_w[g] = qb_q;
	end

	always_ff @(posedge clk) begin
		rd_lvl_q <= rd_lvl;
	end

	assign rd_data_a = qa_w[rd_lvl_q];
	assign rd_data_b = qb_w[rd_lvl_q];

endmodule

`default_nettype wire

// ===== hdl/tpmq_datapath.sv =====
// Datapath: node/level registers, depth memory, lifting tables, result register.
// Depends on tpmq_pkg and tpmq_lift_mem; driven by op codes from tpmq_ctrl.
`timescale 1ns / 1ps
`default_nettype none

module tpmq_datapath #(
	parameter int MAX_NODES = tpmq_pkg::MAX_NODES_DEF,
	parameter int LEVELS    = tpmq_pkg::LEVELS_DEF,
	parameter int WB        = tpmq_pkg::WEIGHT_BITS_DEF
) (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire tpmq_pkg::cmd_t               cmd,
	output tpmq_pkg::stat_t                   stat,
	input  wire logic                         cfg_valid,
	input  wire logic [tpmq_pkg::CFG_W-1:0]   cfg_data,
	input  wire logic [tpmq_pkg::NODE_W-1:0]  node,
	input  wire logic [tpmq_pkg::NODE_W-1:0]  other_node,
	input  wire logic [tpmq_pkg::NODE_W-1:0]  parent_node,
	input  wire logic                         has_parent,
	input  wire logic [tpmq_pkg::DEPTH_W-1:0] node_depth_in,
	input  wire logic [tpmq_pkg::EDGE_W-1:0]  edge_weight,
	input  wire logic                         rsp_stall,
	output logic                              rsp_valid,
	output logic      [WB-1:0]                max_weight
);

	localparam int NW   = $clog2(MAX_NODES);
	localparam int LW   = $clog2(LEVELS);
	localparam int LVW  = $clog2(LEVELS + 1);
	localparam int EW   = 1 + NW + WB;
	localparam int DW   = tpmq_pkg::DEPTH_W;
	localparam int CFW  = tpmq_pkg::CFG_W;
	localparam int SUMW = ((DW > LEVELS) ? DW : LEVELS) + 1;
	localparam int CW   = ((CFW > NW + 1) ? CFW : NW + 1) + 1;

	logic [CFW-1:0] node_count_q;
	logic [NW-1:0]  x_q;
	logic [NW-1:0]  y_q;
	logic [NW-1:0]  p_q;
	logic           hp_q;
	logic [DW-1:0]  dep_q;
	logic [WB-1:0]  w_q;
	logic [DW-1:0]  dy_q;
	logic [WB-1:0]  mx_q;
	logic [LVW-1:0] lvl_q;
	logic [NW-1:0]  idx_q;
	logic [WB-1:0]  smax_q;
	logic           svalid_q;
	logic           rsp_valid_q;
	logic [WB-1:0]  max_weight_q;

	logic [DW-1:0] depth_mem [MAX_NODES];
	logic [DW-1:0] da_q;
	logic [DW-1:0] db_q;

	logic [LEVELS-1:0] wr_en;
	logic [NW-1:0]     wr_addr;
	logic [EW-1:0]     wr_data0;
	logic [EW-1:0]     wr_data_hi;
	logic [NW-1:0]     rd_addr_a;
	logic [LW-1:0]     rd_lvl;
	logic [EW-1:0]     ra;
	logic [EW-1:0]     rb;

	logic          a_valid;
	logic          b_valid;
	logic [NW-1:0] a_anc;
	logic [NW-1:0] b_anc;
	logic [WB-1:0] a_max;
	logic [WB-1:0] b_max;
	logic [WB-1:0] mx_a;
	logic [WB-1:0] mx3;
	logic [WB-1:0] s_m_max;
	logic          p1_take;
	logic          p2_take;
	logic [CW-1:0] cnt;

	tpmq_lift_mem #(
		.MAX_NODES (MAX_NODES),
		.LEVELS    (LEVELS),
		.WB        (WB)
	) u_lift (
		.clk        (clk),
		.wr_en      (wr_en),
		.wr_addr    (wr_addr),
		.wr_data0   (wr_data0),
		.wr_data_hi (wr_data_hi),
		.rd_addr_a  (rd_addr_a),
		.rd_addr_b  (y_q),
		.rd_lvl     (rd_lvl),
		.rd_data_a  (ra),
		.rd_data_b  (rb)
	);

	assign a_valid = ra[EW-1];
	assign a_anc   = ra[NW+WB-1:WB];
	assign a_max   = ra[WB-1:0];
	assign b_valid = rb[EW-1];
	assign b_anc   = rb[NW+WB-1:WB];
	assign b_max   = rb[WB-1:0];

	assign mx_a    = (mx_q > a_max) ? mx_q : a_max;
	assign mx3     = (mx_a > b_max) ? mx_a : b_max;
	assign s_m_max = (smax_q > a_max) ? smax_q : a_max;

	assign p1_take = a_valid &&
		(SUMW'(da_q) >= SUMW'(dy_q) + (SUMW'(1) << lvl_q));
	assign p2_take = a_valid && b_valid && (a_anc != b_anc);

	// Table writes and read addresses per op.
	always_comb begin
		wr_en      = '0;
		wr_addr    = idx_q;
		wr_data0   = '0;
		wr_data_hi = '0;
		rd_addr_a  = x_q;
		rd_lvl     = LW'(lvl_q);
		unique case (cmd.op)
			tpmq_pkg::OP_CLR: begin
				wr_en = '1;
			end
			tpmq_pkg::OP_LOAD: begin
				wr_en   = '1;
				wr_addr = x_q;
				if (hp_q) begin
					wr_data0 = {1'b1, p_q, w_q};
				end
			end
			tpmq_pkg::OP_RD_S: begin
				rd_addr_a = idx_q;
				rd_lvl    = LW'(lvl_q - LVW'(1));
			end
			tpmq_pkg::OP_RD_M: begin
				rd_addr_a = a_anc;
				rd_lvl    = LW'(lvl_q - LVW'(1));
			end
			tpmq_pkg::OP_WR: begin
				wr_en = LEVELS'(1) << lvl_q[LW-1:0];
				if (svalid_q) begin
					wr_data_hi = {a_valid, a_anc, s_m_max};
				end
			end
			tpmq_pkg::OP_F_RD: begin
				rd_lvl = '0;
			end
			default: begin
			end
		endcase
	end

	// Depth memory, read at both current nodes every cycle.
	always_ff @(posedge clk) begin
		if (cmd.op == tpmq_pkg::OP_LOAD) begin
			depth_mem[x_q] <= dep_q;
		end
		da_q <= depth_mem[x_q];
		db_q <= depth_mem[y_q];
	end

	// Payload registers.
	always_ff @(posedge clk) begin
		unique case (cmd.op)
			tpmq_pkg::OP_CAPTURE: begin
				x_q   <= NW'(node);
				y_q   <= NW'(other_node);
				p_q   <= NW'(parent_node);
				hp_q  <= has_parent;
				dep_q <= node_depth_in;
				w_q   <= WB'(edge_weight);
			end
			tpmq_pkg::OP_RD_M: begin
				smax_q   <= a_max;
				svalid_q <= a_valid;
			end
			tpmq_pkg::OP_Q_DEP: begin
				mx_q <= '0;
			end
			tpmq_pkg::OP_Q_SWAP: begin
				if (da_q < db_q) begin
					x_q  <= y_q;
					y_q  <= x_q;
					dy_q <= da_q;
				end else begin
					dy_q <= db_q;
				end
			end
			tpmq_pkg::OP_P1_UPD: begin
				if (p1_take) begin
					mx_q <= mx_a;
					x_q  <= a_anc;
				end
			end
			tpmq_pkg::OP_P2_UPD: begin
				if (p2_take) begin
					mx_q <= mx3;
					x_q  <= a_anc;
					y_q  <= b_anc;
				end
			end
			tpmq_pkg::OP_F_UPD: begin
				mx_q <= mx3;
			end
			tpmq_pkg::OP_OUT: begin
				max_weight_q <= mx_q;
			end
			default: begin
			end
		endcase
	end

	// Control registers: counters, node count, result valid.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			node_count_q <= CFW'(1);
			idx_q        <= '0;
			lvl_q        <= '0;
			rsp_valid_q  <= 1'b0;
		end else begin
			if (cfg_valid) begin
				node_count_q <= cfg_data;
			end
			unique case (cmd.op)
				tpmq_pkg::OP_CLR:      idx_q <= idx_q + NW'(1);
				tpmq_pkg::OP_WR:       idx_q <= idx_q + NW'(1);
				tpmq_pkg::OP_CAPTURE: begin
					idx_q <= '0;
					lvl_q <= LVW'(1);
				end
				tpmq_pkg::OP_NEXT_LVL: begin
					idx_q <= '0;
					lvl_q <= lvl_q + LVW'(1);
				end
				tpmq_pkg::OP_Q_DEP:    lvl_q <= LVW'(LEVELS - 1);
				tpmq_pkg::OP_Q_EQ:     lvl_q <= LVW'(LEVELS - 1);
				tpmq_pkg::OP_P1_UPD:   lvl_q <= lvl_q - LVW'(1);
				tpmq_pkg::OP_P2_UPD:   lvl_q <= lvl_q - LVW'(1);
				default: begin
				end
			endcase
			if (cmd.op == tpmq_pkg::OP_OUT) begin
				rsp_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	// Nodes that take part in a build: node_count, capped at the table depth.
	assign cnt = (CW'(node_count_q) > CW'(MAX_NODES)) ? CW'(MAX_NODES) : CW'(node_count_q);

	always_comb begin
		stat.clr_last = (idx_q == NW'(MAX_NODES - 1));
		stat.lvl_ok   = (CW'(lvl_q) < CW'(LEVELS)) && ((node_count_q >> lvl_q) != '0);
		stat.idx_last = (CW'(idx_q) + CW'(1) >= cnt);
		stat.lvl_zero = (lvl_q == '0);
		stat.xy_equal = (x_q == y_q);
		stat.out_free = !rsp_valid_q || !rsp_stall;
	end

	assign rsp_valid  = rsp_valid_q;
	assign max_weight = max_weight_q;

endmodule

`default_nettype wire

// ===== hdl/tpmq_ctrl.sv =====
// Controller: one-hot sequencer for clearing, load, table build and query.
// Depends on tpmq_pkg; issues op codes to tpmq_datapath, reads its status.
`timescale 1ns / 1ps
`default_nettype none

module tpmq_ctrl (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            req_valid,
	input  wire logic [1:0]      kind,
	output logic                 req_stall,
	input  wire tpmq_pkg::stat_t stat,
	output tpmq_pkg::cmd_t       cmd
);

	typedef enum logic [17:0] {
		S_CLR    = 18'h00001,
		S_IDLE   = 18'h00002,
		S_LOAD   = 18'h00004,
		S_B_CHK  = 18'h00008,
		S_B_S    = 18'h00010,
		S_B_M    = 18'h00020,
		S_B_W    = 18'h00040,
		S_B_NL   = 18'h00080,
		S_Q_DEP  = 18'h00100,
		S_Q_SWAP = 18'h00200,
		S_P1_RD  = 18'h00400,
		S_P1_UPD = 18'h00800,
		S_Q_EQ   = 18'h01000,
		S_P2_RD  = 18'h02000,
		S_P2_UPD = 18'h04000,
		S_F_RD   = 18'h08000,
		S_F_UPD  = 18'h10000,
		S_Q_OUT  = 18'h20000
	} state_t;

	state_t state_q;
	state_t state_d;

	always_comb begin
		state_d = state_q;
		cmd.op  = tpmq_pkg::OP_NONE;
		unique case (state_q)
			S_CLR: begin
				cmd.op = tpmq_pkg::OP_CLR;
				if (stat.clr_last) begin
					state_d = S_IDLE;
				end
			end
			S_IDLE: begin
				if (req_valid) begin
					cmd.op = tpmq_pkg::OP_CAPTURE;
					unique case (kind)
						tpmq_pkg::KIND_LOAD:  state_d = S_LOAD;
						tpmq_pkg::KIND_BUILD: state_d = S_B_CHK;
						tpmq_pkg::KIND_QUERY: state_d = S_Q_DEP;
						default:              state_d = S_IDLE;
					endcase
				end
			end
			S_LOAD: begin
				cmd.op  = tpmq_pkg::OP_LOAD;
				state_d = S_IDLE;
			end
			S_B_CHK: begin
				state_d = stat.lvl_ok ? S_B_S : S_IDLE;
			end
			S_B_S: begin
				cmd.op  = tpmq_pkg::OP_RD_S;
				state_d = S_B_M;
			end
			S_B_M: begin
				cmd.op  = tpmq_pkg::OP_RD_M;
				state_d = S_B_W;
			end
			S_B_W: begin
				cmd.op  = tpmq_pkg::OP_WR;
				state_d = stat.idx_last ? S_B_NL : S_B_S;
			end
			S_B_NL: begin
				cmd.op  = tpmq_pkg::OP_NEXT_LVL;
				state_d = S_B_CHK;
			end
			S_Q_DEP: begin
				cmd.op  = tpmq_pkg::OP_Q_DEP;
				state_d = S_Q_SWAP;
			end
			S_Q_SWAP: begin
				cmd.op  = tpmq_pkg::OP_Q_SWAP;
				state_d = S_P1_RD;
			end
			S_P1_RD: begin
				cmd.op  = tpmq_pkg::OP_P1_RD;
				state_d = S_P1_UPD;
			end
			S_P1_UPD: begin
				cmd.op  = tpmq_pkg::OP_P1_UPD;
				state_d = stat.lvl_zero ? S_Q_EQ : S_P1_RD;
			end
			S_Q_EQ: begin
				cmd.op  = tpmq_pkg::OP_Q_EQ;
				state_d = stat.xy_equal ? S_Q_OUT : S_P2_RD;
			end
			S_P2_RD: begin
				cmd.op  = tpmq_pkg::OP_P2_RD;
				state_d = S_P2_UPD;
			end
			S_P2_UPD: begin
				cmd.op  = tpmq_pkg::OP_P2_UPD;
				state_d = stat.lvl_zero ? S_F_RD : S_P2_RD;
			end
			S_F_RD: begin
				cmd.op  = tpmq_pkg::OP_F_RD;
				state_d = S_F_UPD;
			end
			S_F_UPD: begin
				cmd.op  = tpmq_pkg::OP_F_UPD;
				state_d = S_Q_OUT;
			end
			S_Q_OUT: begin
				if (stat.out_free) begin
					cmd.op  = tpmq_pkg::OP_OUT;
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLR;
		end else begin
			state_q <= state_d;
		end
	end

	assign req_stall = (state_q != S_IDLE);

endmodule

`default_nettype wire

// ===== hdl/tpmq_checker.sv =====
// Port checker for tree_path_max_edge_query, attached by bind.
// Depends on tpmq_pkg and tree_path_max_edge_query_macros.svh.
`timescale 1ns / 1ps
`default_nettype none
`include "tree_path_max_edge_query_macros.svh"

module tpmq_checker #(
	parameter int WB = tpmq_pkg::WEIGHT_BITS_DEF
) (
	input wire logic          clk,
	input wire logic          arst_n,
	input wire logic          req_valid,
	input wire logic          req_stall,
	input wire logic [1:0]    kind,
	input wire logic          rsp_valid,
	input wire logic          rsp_stall,
	input wire logic [WB-1:0] max_weight
);

	// Hold a stalled result.
	`TPMQ_ASSERT_NEXT(a_rsp_hold, clk, arst_n, rsp_valid && rsp_stall, rsp_valid && $stable(max_weight))

	// An accepted query keeps the block busy for the next cycle.
	`TPMQ_ASSERT_NEXT(a_query_busy, clk, arst_n, req_valid && !req_stall && kind == tpmq_pkg::KIND_QUERY, req_stall)

	// Loads, builds and unknown kinds never raise a result.
	`TPMQ_ASSERT_NEXT(a_no_spurious, clk, arst_n, req_valid && !req_stall && kind != tpmq_pkg::KIND_QUERY && !rsp_valid, !rsp_valid)

	// A new result leaves the block ready for the next item.
	`TPMQ_ASSERT_SAME(a_done_idle, clk, arst_n, $rose(rsp_valid), !req_stall)

endmodule

bind tree_path_max_edge_query tpmq_checker #(.WB(WEIGHT_BITS)) u_tpmq_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.req_valid  (req_valid),
	.req_stall  (req_stall),
	.kind       (kind),
	.rsp_valid  (rsp_valid),
	.rsp_stall  (rsp_stall),
	.max_weight (max_weight)
);

`default_nettype wire

// ===== test/tree_path_max_edge_query_test.sv =====
// Testbench for tree_path_max_edge_query: loads random rooted trees, builds the
// lifting tables and checks every path maximum against a local tree model.
// Depends on tpmq_pkg and the tree_path_max_edge_query RTL.
`timescale 1ns / 1ps

module tree_path_max_edge_query_test;

	localparam int NODES  = 65536;
	localparam int LVLS   = 17;
	localparam int W_BITS = 20;
	localparam int ITEM_TARGET = 1700;

	localparam int NODE_W  = tpmq_pkg::NODE_W;
	localparam int DEPTH_W = tpmq_pkg::DEPTH_W;
	localparam int EDGE_W  = tpmq_pkg::EDGE_W;
	localparam int CFG_W   = tpmq_pkg::CFG_W;
	localparam logic [1:0] KIND_LOAD  = tpmq_pkg::KIND_LOAD;
	localparam logic [1:0] KIND_BUILD = tpmq_pkg::KIND_BUILD;
	localparam logic [1:0] KIND_QUERY = tpmq_pkg::KIND_QUERY;
	// unused kind code, dropped by the block
	localparam logic [1:0] KIND_SKIP  = 2'd3;

	typedef struct packed {
		logic [1:0]         kind;
		logic [NODE_W-1:0]  a;
		logic [NODE_W-1:0]  b;
		logic [NODE_W-1:0]  p;
		logic               hp;
		logic [DEPTH_W-1:0] dep;
		logic [EDGE_W-1:0]  w;
	} tree_item_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [CFG_W-1:0] cfg_data = '0;
	logic req_valid = 1'b0;
	logic req_stall;
	logic [1:0] kind = KIND_LOAD;
	logic [NODE_W-1:0] node = '0;
	logic [NODE_W-1:0] other_node = '0;
	logic [NODE_W-1:0] parent_node = '0;
	logic has_parent = 1'b0;
	logic [DEPTH_W-1:0] node_depth_in = '0;
	logic [EDGE_W-1:0] edge_weight = '0;
	logic rsp_valid;
	logic rsp_stall = 1'b0;
	logic [W_BITS-1:0] max_weight;

	tree_path_max_edge_query i_dut (
		.clk(clk), .arst_n(arst_n),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
		.req_valid(req_valid), .req_stall(req_stall), .kind(kind), .node(node),
		.other_node(other_node), .parent_node(parent_node), .has_parent(has_parent),
		.node_depth_in(node_depth_in), .edge_weight(edge_weight),
		.rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .max_weight(max_weight)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Tree model: sparse tables keyed by node*LVLS+level; missing entries read as
	// cleared (no ancestor, weight 0).
	int unsigned       tree_count = 1;
	logic [15:0]       depth_mem[int];
	logic [15:0]       anc_mem[int];
	bit                anc_ok[int];
	logic [W_BITS-1:0] wmax_mem[int];

	tree_item_t        pending_items[$];
	logic [W_BITS-1:0] expected_max[$];
	int                fails = 0;
	int                send_idle_pct = 17;
	int                recv_stall_pct = 81;
	bit                req_fire = 1'b0;

	function automatic bit ok_at(int n, int l);
		int s;
		s = n * LVLS + l;
		return anc_ok.exists(s) ? anc_ok[s] : 1'b0;
	endfunction

	function automatic int anc_at(int n, int l);
		int s;
		s = n * LVLS + l;
		return anc_mem.exists(s) ? int'(anc_mem[s]) : 0;
	endfunction

	function automatic logic [W_BITS-1:0] wmax_at(int n, int l);
		int s;
		s = n * LVLS + l;
		return wmax_mem.exists(s) ? wmax_mem[s] : '0;
	endfunction

	function automatic int depth_at(int n);
		return depth_mem.exists(n) ? int'(depth_mem[n]) : 0;
	endfunction

	function automatic logic [W_BITS-1:0] wbig(logic [W_BITS-1:0] x, logic [W_BITS-1:0] y);
		return (x > y) ? x : y;
	endfunction

	task automatic build_lift_tables();
		int cnt;
		int mid;
		cnt = (tree_count > NODES) ? NODES : int'(tree_count);
		for (int j = 1; j < LVLS && (longint'(1) << j) <= longint'(tree_count); j++) begin
			for (int i = 0; i < cnt; i++) begin
				if (!ok_at(i, j - 1)) begin
					anc_ok[i * LVLS + j] = 1'b0;
					continue;
				end
				mid = anc_at(i, j - 1);
				anc_ok[i * LVLS + j]   = ok_at(mid, j - 1);
				anc_mem[i * LVLS + j]  = anc_at(mid, j - 1);
				wmax_mem[i * LVLS + j] = wbig(wmax_at(i, j - 1), wmax_at(mid, j - 1));
			end
		end
	endtask

	function automatic logic [W_BITS-1:0] path_max_predict(int x, int y);
		logic [W_BITS-1:0] mx;
		int t;
		int nx;
		int ny;
		mx = '0;
		if (depth_at(x) < depth_at(y)) begin
			t = x;
			x = y;
			y = t;
		end
		// climb the deeper node to the other's depth
		for (int i = LVLS - 1; i >= 0; i--) begin
			if (longint'(depth_at(x)) >= longint'(depth_at(y)) + (longint'(1) << i)
					&& ok_at(x, i)) begin
				mx = wbig(mx, wmax_at(x, i));
				x = anc_at(x, i);
			end
		end
		if (x == y)
			return mx;
		// climb both to just below the common ancestor
		for (int i = LVLS - 1; i >= 0; i--) begin
			nx = anc_at(x, i);
			ny = anc_at(y, i);
			if (ok_at(x, i) && ok_at(y, i) && nx != ny) begin
				mx = wbig(mx, wbig(wmax_at(x, i), wmax_at(y, i)));
				x = nx;
				y = ny;
			end
		end
		mx = wbig(mx, wbig(wmax_at(x, 0), wmax_at(y, 0)));
		return mx;
	endfunction

	task automatic tree_apply(tree_item_t it);
		int a;
		a = int'(it.a);
		if (it.kind == KIND_LOAD) begin
			depth_mem[a] = it.dep;
			anc_ok[a * LVLS]   = it.hp;
			anc_mem[a * LVLS]  = it.hp ? it.p : '0;
			wmax_mem[a * LVLS] = it.hp ? it.w : '0;
			for (int l = 1; l < LVLS; l++) begin
				anc_ok[a * LVLS + l]   = 1'b0;
				wmax_mem[a * LVLS + l] = '0;
			end
		end else if (it.kind == KIND_BUILD) begin
			build_lift_tables();
		end else if (it.kind == KIND_QUERY) begin
			expected_max = {expected_max, path_max_predict(a, int'(it.b))};
		end
	endtask

	// Monitor: take accepted items into the model, check accepted results.
	always @(posedge clk) begin
		if (arst_n) begin
			req_fire <= req_valid && !req_stall;
			if (req_valid && !req_stall)
				tree_apply('{kind, node, other_node, parent_node, has_parent,
					node_depth_in, edge_weight});
			if (rsp_valid && !rsp_stall) begin
				if (expected_max.size() == 0) begin
					$display("%0t: max_weight with none expected, actual %0d", $time,
						max_weight);
					fails++;
				end else begin
					if (max_weight !== expected_max[0]) begin
						$display("%0t: max_weight expected %0d actual %0d", $time,
							expected_max[0], max_weight);
						fails++;
					end
					void'(expected_max.pop_front());
				end
			end
		end
	end

	// Driver: advance to the next item after acceptance, idle at random.
	always @(negedge clk) begin
		if (arst_n) begin
			if (!req_valid || req_fire) begin
				if (pending_items.size() > 0 && $urandom_range(0, 99) >= send_idle_pct) begin
					tree_item_t it;
					it = pending_items.pop_front();
					kind          <= it.kind;
					node          <= it.a;
					other_node    <= it.b;
					parent_node   <= it.p;
					has_parent    <= it.hp;
					node_depth_in <= it.dep;
					edge_weight   <= it.w;
					req_valid     <= 1'b1;
				end else begin
					req_valid <= 1'b0;
				end
			end
			rsp_stall <= ($urandom_range(0, 99) < recv_stall_pct);
		end
	end

	int pushed = 0;
	int gen_depth[int];
	int phase_ids[$];
	int known_ids[$];

	function automatic logic [EDGE_W-1:0] pick_weight();
		case ($urandom_range(0, 7))
			0: return '0;
			1: return '1;
			default: return EDGE_W'($urandom);
		endcase
	endfunction

	task automatic push_item(logic [1:0] k, int a, int b, int p, bit hp, int d,
			logic [EDGE_W-1:0] w);
		tree_item_t it;
		it = '{k, NODE_W'(a), NODE_W'(b), NODE_W'(p), hp, DEPTH_W'(d), w};
		pending_items = {pending_items, it};
		if (k != KIND_SKIP)
			pushed++;
	endtask

	// Load node n under parent p (or as a root when p < 0).
	task automatic load_node(int n, int p);
		if (p < 0) begin
			gen_depth[n] = 0;
			push_item(KIND_LOAD, n, $urandom, $urandom, 1'b0, 0, pick_weight());
		end else begin
			gen_depth[n] = gen_depth[p] + 1;
			push_item(KIND_LOAD, n, $urandom, p, 1'b1, gen_depth[n], pick_weight());
		end
		phase_ids = {phase_ids, n};
		known_ids = {known_ids, n};
	endtask

	task automatic write_node_count(int unsigned v);
		@(negedge clk);
		cfg_data  <= CFG_W'(v);
		cfg_valid <= 1'b1;
		do @(posedge clk); while (!cfg_ready);
		tree_count = v;
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	task automatic drain();
		wait (pending_items.size() == 0 && !req_valid && expected_max.size() == 0);
		repeat (100) @(posedge clk);
	endtask

	initial begin
		int unsigned n_cfg;
		int n_nodes;
		int x;
		int y;
		int extra;
		bit chain;
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		for (int ph = 0; pushed < ITEM_TARGET; ph++) begin
			// sender busy, receiver lazy; then the reverse; then neither idles
			if (pushed < ITEM_TARGET / 3) begin
				send_idle_pct = 17;
				recv_stall_pct = 81;
			end else if (pushed < 2 * ITEM_TARGET / 3) begin
				send_idle_pct = 81;
				recv_stall_pct = 17;
			end else begin
				send_idle_pct = 0;
				recv_stall_pct = 0;
			end
			case (ph)
				0: n_cfg = 1;
				1: n_cfg = 2;
				2: n_cfg = 0;
				3: n_cfg = 65536;
				default: n_cfg = (ph % 6 == 5) ? $urandom_range(65, 131071)
					: $urandom_range(2, 64);
			endcase
			write_node_count(n_cfg);
			phase_ids.delete();
			// large counts would make a build far too slow: use scattered ids
			// and skip the build there
			n_nodes = (n_cfg <= 64) ? int'(n_cfg) : 20;
			if (n_nodes == 0)
				n_nodes = 2;
			chain = ($urandom_range(0, 3) == 0);
			for (int i = 0; i < n_nodes; i++) begin
				if (n_cfg <= 64)
					x = i;
				else if (ph == 3 && i < 2)
					x = i ? 65535 : 0;
				else
					x = $urandom_range(0, 65535);
				if (i == 0)
					load_node(x, -1);
				else
					load_node(x, chain ? phase_ids[i - 1]
						: phase_ids[$urandom_range(0, i - 1)]);
			end
			// leaves with random ids, one with an arbitrary depth, and a dropped kind
			for (int e = 0; e < 3; e++)
				load_node($urandom_range(0, 65535),
					phase_ids[$urandom_range(0, phase_ids.size() - 1)]);
			extra = $urandom_range(0, 65535);
			gen_depth[extra] = $urandom_range(0, 65535);
			push_item(KIND_LOAD, extra, $urandom, phase_ids[0], 1'b1,
				($urandom_range(0, 3) == 0) ? 65535 : gen_depth[extra], pick_weight());
			known_ids = {known_ids, extra};
			push_item(KIND_SKIP, $urandom, $urandom, $urandom, 1'b1, $urandom, pick_weight());
			if (n_cfg <= 64)
				push_item(KIND_BUILD, $urandom, $urandom, $urandom, $urandom, $urandom,
					pick_weight());
			for (int q = 0; q < ((ph < 3) ? 3 : 25); q++) begin
				x = ($urandom_range(0, 4) == 0) ? known_ids[$urandom_range(0,
					known_ids.size() - 1)] : phase_ids[$urandom_range(0, phase_ids.size() - 1)];
				y = ($urandom_range(0, 9) == 0) ? x
					: phase_ids[$urandom_range(0, phase_ids.size() - 1)];
				push_item(KIND_QUERY, x, y, $urandom, $urandom, $urandom, pick_weight());
			end
			// hold the sender until every result of this tree is back
			drain();
		end
		drain();
		repeat (200) @(posedge clk);
		if (fails == 0)
			$display("tree_path_max_edge_query verification clean");
		else
			$display("tree_path_max_edge_query verification failed");
		$finish;
	end

	// Clearing pass, slow handshakes and small builds fit far inside this bound.
	initial begin
		#50_000_000;
		$display("tree_path_max_edge_query verification failed");
		$finish;
	end

endmodule
